[design/bpm_average_dwell_alert_unit_assert.svh]
// Assertion macros shared by the BPM average and dwell alert unit.
`ifndef BPM_AVERAGE_DWELL_ALERT_UNIT_ASSERT_SVH
`define BPM_AVERAGE_DWELL_ALERT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BADA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bada: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BADA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bada: next-cycle check failed");

`endif

[design/bada_pkg.sv]
// Shared types and constants of the BPM average and dwell alert unit.
package bada_pkg;

    localparam int ADC_W      = 12;
    localparam int TS_W       = 32;
    localparam int BPM_W      = 7;
    localparam int KIND_W     = 3;
    localparam int POST_W     = 2;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SOS    = 2'd2;

    localparam logic [POST_W-1:0] POSTURE_NORMAL = 2'd0;
    localparam logic [POST_W-1:0] POSTURE_TILTED = 2'd1;
    localparam logic [POST_W-1:0] POSTURE_FALL   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        ALERT_NONE = 3'd0,
        ALERT_LOW  = 3'd1,
        ALERT_HIGH = 3'd2,
        ALERT_FALL = 3'd3,
        ALERT_SOS  = 3'd4
    } t_alert;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL  = 3'd0,
        CFG_DWELL     = 3'd1,
        CFG_CRIT_LOW  = 3'd2,
        CFG_CRIT_HIGH = 3'd3,
        CFG_FALL_LOW  = 3'd4,
        CFG_FALL_HIGH = 3'd5,
        CFG_MONITOR   = 3'd6
    } t_cfg_idx;

    localparam logic [15:0] RST_INTERVAL  = 16'd200;
    localparam logic [15:0] RST_DWELL     = 16'd2000;
    localparam logic [7:0]  RST_CRIT_LOW  = 8'd40;
    localparam logic [7:0]  RST_CRIT_HIGH = 8'd120;
    localparam logic [11:0] RST_FALL_LOW  = 12'd500;
    localparam logic [11:0] RST_FALL_HIGH = 12'd3500;

    localparam logic [BPM_W-1:0] BPM_INIT = 7'd65;

    typedef struct packed {
        logic [15:0] interval;
        logic [15:0] dwell;
        logic [7:0]  crit_low;
        logic [7:0]  crit_high;
        logic [11:0] fall_low;
        logic [11:0] fall_high;
        logic        monitor;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic map;
        logic push;
        logic sum;
        logic div;
        logic alert;
        logic evt;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_sample;
        logic push_due;
        logic sum_last;
        logic div_last;
    } t_status;

endpackage

[design/bpm_average_dwell_alert_unit.sv]
// Top level of the BPM average and dwell alert unit.
// The block takes one item at a time and returns one result for each. A clear or SOS
// item passes through the EVT and DONE states; a sample that is not pushed passes through
// MAP, PUSH, ALERT and DONE; a pushed sample also passes through SUM and DIV, the serial
// sum over the ring (one entry a cycle) and the restoring divide by the fill count (one
// quotient bit a cycle). The next item is accepted as soon as the result sits in the
// output register.
module bpm_average_dwell_alert_unit
    import bada_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [ADC_W-1:0]      i_tilt_adc,
    input  logic [ADC_W-1:0]      i_pulse_adc,
    input  logic [TS_W-1:0]       i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BPM_W-1:0]      o_bpm_now,
    output logic [BPM_W-1:0]      o_bpm_avg,
    output logic                  o_alert_on,
    output logic [KIND_W-1:0]     o_alert_kind,
    output logic [POST_W-1:0]     o_posture,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    bada_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    bada_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    bada_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (cfg),
        .i_req_type   (i_req_type),
        .i_tilt_adc   (i_tilt_adc),
        .i_pulse_adc  (i_pulse_adc),
        .i_now_ms     (i_now_ms),
        .o_status     (status),
        .o_bpm_now    (o_bpm_now),
        .o_bpm_avg    (o_bpm_avg),
        .o_alert_on   (o_alert_on),
        .o_alert_kind (o_alert_kind),
        .o_posture    (o_posture)
    );

endmodule

[design/bada_cfg.sv]
// Configuration register file of the BPM average and dwell alert unit.
module bada_cfg
    import bada_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = i_rst_n;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval  <= RST_INTERVAL;
            r_cfg.dwell     <= RST_DWELL;
            r_cfg.crit_low  <= RST_CRIT_LOW;
            r_cfg.crit_high <= RST_CRIT_HIGH;
            r_cfg.fall_low  <= RST_FALL_LOW;
            r_cfg.fall_high <= RST_FALL_HIGH;
            r_cfg.monitor   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_INTERVAL:  r_cfg.interval  <= i_cfg_data;
                CFG_DWELL:     r_cfg.dwell     <= i_cfg_data;
                CFG_CRIT_LOW:  r_cfg.crit_low  <= i_cfg_data[7:0];
                CFG_CRIT_HIGH: r_cfg.crit_high <= i_cfg_data[7:0];
                CFG_FALL_LOW:  r_cfg.fall_low  <= i_cfg_data[11:0];
                CFG_FALL_HIGH: r_cfg.fall_high <= i_cfg_data[11:0];
                CFG_MONITOR:   r_cfg.monitor   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

[design/bada_ctrl.sv]
// Sequencing state machine of the BPM average and dwell alert unit.
`include "bpm_average_dwell_alert_unit_assert.svh"

module bada_ctrl
    import bada_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MAP   = 8'b0000_0010,
        ST_PUSH  = 8'b0000_0100,
        ST_SUM   = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_ALERT = 8'b0010_0000,
        ST_EVT   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   in_fire;
    logic   out_free;

    assign in_fire     = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !i_rst_n || (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = in_fire;
        o_cmd.map      = (r_state == ST_MAP);
        o_cmd.push     = (r_state == ST_PUSH) && i_status.push_due;
        o_cmd.sum      = (r_state == ST_SUM);
        o_cmd.div      = (r_state == ST_DIV);
        o_cmd.alert    = (r_state == ST_ALERT);
        o_cmd.evt      = (r_state == ST_EVT);
        o_cmd.load_out = (r_state == ST_DONE) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.in_sample ? ST_MAP : ST_EVT;
                end
            end
            ST_MAP:   n_state = ST_PUSH;
            ST_PUSH:  n_state = i_status.push_due ? ST_SUM : ST_ALERT;
            ST_SUM:   n_state = i_status.sum_last ? ST_DIV : ST_SUM;
            ST_DIV:   n_state = i_status.div_last ? ST_ALERT : ST_DIV;
            ST_ALERT: n_state = ST_DONE;
            ST_EVT:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `BADA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, r_state != ST_IDLE)
    `BADA_ASSERT_NEXT(a_result_after_load, i_clk, i_rst_n, o_cmd.load_out, r_out_valid)

endmodule

[design/bada_dpath.sv]
// Datapath of the BPM average and dwell alert unit: mapping, ring, divider, alerts.
`include "bpm_average_dwell_alert_unit_assert.svh"

module bada_dpath
    import bada_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_cfg              i_cfg,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [ADC_W-1:0]  i_tilt_adc,
    input  logic [ADC_W-1:0]  i_pulse_adc,
    input  logic [TS_W-1:0]   i_now_ms,
    output t_status           o_status,
    output logic [BPM_W-1:0]  o_bpm_now,
    output logic [BPM_W-1:0]  o_bpm_avg,
    output logic              o_alert_on,
    output logic [KIND_W-1:0] o_alert_kind,
    output logic [POST_W-1:0] o_posture
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = BPM_W + CNT_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam logic [ADC_W-1:0] ADC_LOW_KNEE  = 12'd1000;
    localparam logic [ADC_W-1:0] ADC_HIGH_KNEE = 12'd3000;
    localparam logic [BPM_W-1:0] BPM_MID_BASE  = 7'd50;
    localparam logic [BPM_W-1:0] BPM_HIGH_BASE = 7'd80;
    localparam logic [21:0]      DIV25_MUL     = 22'd1311;

    // floor(x / 25) for x below 4681
    function automatic logic [BPM_W-1:0] div25(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * DIV25_MUL;
        return p[21:15];
    endfunction

    logic [REQ_W-1:0]  r_req;
    logic [ADC_W-1:0]  r_tilt;
    logic [ADC_W-1:0]  r_pulse;
    logic [TS_W-1:0]   r_now;
    logic [BPM_W-1:0]  r_bpm_now;

    logic [BPM_W-1:0]  r_ring [WINDOW];
    logic [IDX_W-1:0]  r_wpos;
    logic [CNT_W-1:0]  r_filled;
    logic [BPM_W-1:0]  r_avg;
    logic [TS_W-1:0]   r_last_push;

    logic [SUM_W-1:0]  r_acc;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [DCNT_W-1:0] r_dcnt;

    logic              r_flag, n_flag;
    logic [TS_W-1:0]   r_start, n_start;
    logic              r_latched, n_latched;
    t_alert            r_code, n_code;

    logic [BPM_W-1:0]  r_o_bpm_now;
    logic [BPM_W-1:0]  r_o_avg;
    logic              r_o_alert_on;
    logic [KIND_W-1:0] r_o_kind;
    logic [POST_W-1:0] r_o_posture;

    logic [ADC_W-1:0]  off_hi;
    logic [ADC_W-1:0]  off_mid;
    logic [12:0]       mid3;
    logic [BPM_W-1:0]  map_bpm;
    logic              is_fall;
    logic              is_tilted;
    logic [POST_W-1:0] posture;
    logic [SUM_W-1:0]  acc_sum;
    logic [CNT_W:0]    rem_sh;
    logic              rem_ge;
    logic [CNT_W:0]    rem_nx;
    logic [SUM_W-1:0]  quo_nx;
    logic              crit_lo;
    logic              crit_hi;
    logic [TS_W-1:0]   dwell_elapsed;

    // pulse reading to BPM
    assign off_hi  = r_pulse - ADC_HIGH_KNEE;
    assign off_mid = r_pulse - ADC_LOW_KNEE;
    assign mid3    = {off_mid, 1'b0} + 13'(off_mid);

    always_comb begin
        if (r_pulse < ADC_LOW_KNEE) begin
            map_bpm = div25(r_pulse[10:0]);
        end else if (r_pulse > ADC_HIGH_KNEE) begin
            map_bpm = BPM_HIGH_BASE + div25(off_hi[10:0]);
        end else begin
            map_bpm = BPM_MID_BASE + div25(11'(mid3[12:3]));
        end
    end

    assign is_fall   = (r_tilt < i_cfg.fall_low) || (r_tilt > i_cfg.fall_high);
    assign is_tilted = ((r_tilt > ADC_HIGH_KNEE) && (r_tilt < i_cfg.fall_high)) ||
                       ((r_tilt < ADC_LOW_KNEE) && (r_tilt > i_cfg.fall_low));
    assign posture   = is_fall ? POSTURE_FALL : (is_tilted ? POSTURE_TILTED : POSTURE_NORMAL);

    // serial sum and restoring divide
    assign acc_sum = r_acc + SUM_W'(r_ring[r_idx]);
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_filled});
    assign rem_nx  = rem_ge ? (rem_sh - {1'b0, r_filled}) : rem_sh;
    assign quo_nx  = {r_quo[SUM_W-2:0], rem_ge};

    assign o_status.in_sample = (i_req_type == REQ_SAMPLE);
    assign o_status.push_due  = ((r_now - r_last_push) >= TS_W'(i_cfg.interval));
    assign o_status.sum_last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_filled);
    assign o_status.div_last  = (r_dcnt == DCNT_W'(SUM_W - 1));

    // alert and event update
    assign crit_lo = (8'(r_avg) < i_cfg.crit_low);
    assign crit_hi = (8'(r_avg) > i_cfg.crit_high);

    always_comb begin
        n_flag        = r_flag;
        n_start       = r_start;
        n_latched     = r_latched;
        n_code        = r_code;
        dwell_elapsed = '0;
        if (i_cmd.alert && i_cfg.monitor && !r_latched) begin
            if (!r_flag && (crit_lo || crit_hi)) begin
                n_flag  = 1'b1;
                n_start = r_now;
            end else if (r_flag && !(crit_lo || crit_hi)) begin
                n_flag = 1'b0;
            end
            dwell_elapsed = r_now - n_start;
            if (n_flag && (dwell_elapsed >= TS_W'(i_cfg.dwell))) begin
                if (crit_lo) begin
                    n_latched = 1'b1;
                    n_code    = ALERT_LOW;
                end else if (crit_hi) begin
                    n_latched = 1'b1;
                    n_code    = ALERT_HIGH;
                end
            end
            if (is_fall) begin
                n_latched = 1'b1;
                n_code    = ALERT_FALL;
            end
        end
        if (i_cmd.evt) begin
            case (r_req)
                REQ_CLEAR: begin
                    n_latched = 1'b0;
                    n_code    = ALERT_NONE;
                end
                REQ_SOS: begin
                    n_latched = 1'b1;
                    n_code    = ALERT_SOS;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req   <= i_req_type;
            r_tilt  <= i_tilt_adc;
            r_pulse <= i_pulse_adc;
            r_now   <= i_now_ms;
        end
        if (i_cmd.map) begin
            r_bpm_now <= map_bpm;
        end
        if (i_cmd.push) begin
            r_acc <= '0;
            r_idx <= '0;
        end
        if (i_cmd.sum) begin
            r_acc  <= acc_sum;
            r_idx  <= r_idx + IDX_W'(1);
            r_quo  <= acc_sum;
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div) begin
            r_quo  <= quo_nx;
            r_rem  <= rem_nx[CNT_W-1:0];
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.load_out) begin
            r_o_bpm_now  <= (r_req == REQ_SAMPLE) ? r_bpm_now : '0;
            r_o_avg      <= r_avg;
            r_o_alert_on <= r_latched;
            r_o_kind     <= r_code;
            r_o_posture  <= (r_req == REQ_SAMPLE) ? posture : POSTURE_NORMAL;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= BPM_INIT;
            end
            r_wpos      <= '0;
            r_filled    <= '0;
            r_avg       <= BPM_INIT;
            r_last_push <= '0;
            r_flag      <= 1'b0;
            r_start     <= '0;
            r_latched   <= 1'b0;
            r_code      <= ALERT_NONE;
        end else begin
            if (i_cmd.push) begin
                r_ring[r_wpos] <= r_bpm_now;
                r_wpos         <= (r_wpos == IDX_W'(WINDOW - 1)) ? '0 : r_wpos + IDX_W'(1);
                if (r_filled != CNT_W'(WINDOW)) begin
                    r_filled <= r_filled + CNT_W'(1);
                end
                r_last_push <= r_now;
            end
            if (i_cmd.div && o_status.div_last) begin
                r_avg <= quo_nx[BPM_W-1:0];
            end
            r_flag    <= n_flag;
            r_start   <= n_start;
            r_latched <= n_latched;
            r_code    <= n_code;
        end
    end

    assign o_bpm_now    = r_o_bpm_now;
    assign o_bpm_avg    = r_o_avg;
    assign o_alert_on   = r_o_alert_on;
    assign o_alert_kind = r_o_kind;
    assign o_posture    = r_o_posture;

    `BADA_ASSERT_IMPL(a_latch_matches_code, i_clk, i_rst_n, 1'b1, r_latched == (r_code != ALERT_NONE))
    `BADA_ASSERT_IMPL(a_fill_in_range, i_clk, i_rst_n, 1'b1, r_filled <= CNT_W'(WINDOW))

endmodule
